### rtl/tevq_pkg.sv
// tevq_pkg: shared beat types and fixed constants for the tetrahedron quality pipeline
// no dependencies
package tevq_pkg;

  // coordinate width, fixed by the beat type
  localparam int IN_W   = 16;
  localparam int QUAL_W = 32;

  // limb width of the pipelined multipliers
  localparam int LIMB_W = 32;

  // 6*53033^2, the reduced numerator of 24*(8.48528)^2
  localparam int          CN_W = 34;
  localparam logic [33:0] CN   = 34'd16874994534;

  // 5^10, the reduced denominator
  localparam int          F10_W = 24;
  localparam logic [23:0] F10   = 24'd9765625;

  typedef struct packed {
    logic signed [IN_W-1:0] a_x;
    logic signed [IN_W-1:0] a_y;
    logic signed [IN_W-1:0] a_z;
    logic signed [IN_W-1:0] b_x;
    logic signed [IN_W-1:0] b_y;
    logic signed [IN_W-1:0] b_z;
    logic signed [IN_W-1:0] c_x;
    logic signed [IN_W-1:0] c_y;
    logic signed [IN_W-1:0] c_z;
    logic signed [IN_W-1:0] d_x;
    logic signed [IN_W-1:0] d_y;
    logic signed [IN_W-1:0] d_z;
  } tevq_in_t;

  typedef struct packed {
    logic signed [QUAL_W-1:0] quality;
    logic                     degenerate;
  } tevq_out_t;

  // per-item flags that ride along the pipeline
  typedef struct packed {
    logic neg;
    logic zero;
  } tevq_tag_t;

endpackage

### rtl/tetra_edge_volume_quality.sv
// tetra_edge_volume_quality: top level of the tetrahedron quality pipeline
// depends on tevq_pkg, tevq_geom, tevq_mul, tevq_div, tevq_sqrt
//
// One tetrahedron beat is taken on every clock where start is high and busy is low; busy is
// high only during reset. Each beat produces exactly one result, shown with done for one
// cycle. Each beat passes through the geometry front end, whose wide products are split into
// 32-bit limb multiplies, the long divider, which resolves one quotient bit per stage, and
// the square root, one root bit per stage; throughput is one beat per cycle. The receiver
// cannot stall: results must be captured when done is high. Quality is rounded to nearest,
// negative for an inverted element, and forced to zero with degenerate set when the volume
// is zero.
module tetra_edge_volume_quality import tevq_pkg::*; #(
  parameter int QUALITY_FRAC_BITS = 30
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  tevq_in_t  tetra,
  output logic      done,
  output tevq_out_t result
);

  localparam int EW  = IN_W + 1;
  localparam int CRW = 2 * EW + 1;
  localparam int TW  = EW + CRW;
  localparam int DW  = TW + 2;
  localparam int SW  = 2 * EW + 5;
  localparam int NW  = 2 * DW + CN_W;
  localparam int QW  = 3 * SW + F10_W;
  localparam int SH  = 2 * QUALITY_FRAC_BITS;
  localparam int QB  = 2 * QUALITY_FRAC_BITS + 3;
  localparam int RB  = (QB + 1) / 2;
  localparam int LAT = 12 + (QB + 1) + (RB + 1) + 1;

  localparam logic [RB-1:0] FULL = RB'(1) << QUALITY_FRAC_BITS;
  localparam logic [RB-1:0] SATV = RB'(64'h7FFF_FFFF);

  assign busy = rst;

  logic          acc;
  assign acc = start & ~busy;

  logic          g_valid;
  tevq_tag_t     g_tag;
  logic [NW-1:0] g_num;
  logic [QW-1:0] g_den;

  tevq_geom #(.CB(IN_W), .NW(NW), .QW(QW)) u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (acc),
    .in_beat   (tetra),
    .out_valid (g_valid),
    .out_tag   (g_tag),
    .out_num   (g_num),
    .out_den   (g_den)
  );

  logic          d_valid;
  tevq_tag_t     d_tag;
  logic [QB-1:0] d_quot;

  tevq_div #(.NW(NW), .QW(QW), .SH(SH), .QB(QB)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_tag    (g_tag),
    .in_num    (g_num),
    .in_den    (g_den),
    .out_valid (d_valid),
    .out_tag   (d_tag),
    .out_quot  (d_quot)
  );

  logic          r_valid;
  tevq_tag_t     r_tag;
  logic [RB-1:0] r_root;

  tevq_sqrt #(.QB(QB), .RB(RB)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_tag    (d_tag),
    .in_val    (d_quot),
    .out_valid (r_valid),
    .out_tag   (r_tag),
    .out_root  (r_root)
  );

  // round: largest n with (2n-1) <= root, then clamp and sign
  logic [RB:0]         rp1;
  logic [RB-1:0]       n;
  logic [RB-1:0]       nc;
  logic [QUAL_W-1:0]   m32;
  tevq_out_t           res_next;

  always_comb begin
    rp1 = {1'b0, r_root} + (RB+1)'(1);
    n   = rp1[RB:1];
    nc  = (n > FULL) ? FULL : n;
    nc  = (nc > SATV) ? SATV : nc;
    m32 = QUAL_W'(nc);
    if (r_tag.zero) begin
      res_next.quality    = '0;
      res_next.degenerate = 1'b1;
    end else begin
      res_next.quality    = r_tag.neg ? -$signed(m32) : $signed(m32);
      res_next.degenerate = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r_valid;
    end
    result <= res_next;
  end

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    acc |-> ##LAT done) else $error("result missing after accepted beat");

  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    !acc |-> ##LAT !done) else $error("result without an accepted beat");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.degenerate |-> result.quality == '0)
    else $error("degenerate result with nonzero quality");
`endif

endmodule

### rtl/tevq_geom.sv
// tevq_mul: pipelined limb multiplier; tevq_geom: edge and volume arithmetic, twelve stages
// depends on tevq_pkg; produces the exact numerator and denominator of four times quality squared
module tevq_mul import tevq_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int PW = 64
) (
  input  logic          clk,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [PW-1:0] p
);

  localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
  localparam int NB = (BW + LIMB_W - 1) / LIMB_W;

  logic [NA*LIMB_W-1:0] ap;
  logic [NB*LIMB_W-1:0] bp;
  logic [2*LIMB_W-1:0]  pp [NA][NB];
  logic [PW-1:0]        row_next [NA];
  logic [PW-1:0]        row [NA];
  logic [PW-1:0]        p_next;

  assign ap = (NA*LIMB_W)'(a);
  assign bp = (NB*LIMB_W)'(b);

  // stage 1: limb products
  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp[i][j] <= ap[i*LIMB_W +: LIMB_W] * bp[j*LIMB_W +: LIMB_W];
      end
    end
  end

  // stage 2: one sum per limb of a
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (PW'(pp[i][j]) << (j * LIMB_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    row <= row_next;
  end

  // stage 3: final sum
  always_comb begin
    p_next = '0;
    for (int i = 0; i < NA; i++) begin
      p_next = p_next + (row[i] << (i * LIMB_W));
    end
  end

  always_ff @(posedge clk) begin
    p <= p_next;
  end

endmodule

module tevq_geom import tevq_pkg::*; #(
  parameter int CB = 16,
  parameter int NW = 142,
  parameter int QW = 141
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  tevq_in_t         in_beat,
  output logic             out_valid,
  output tevq_tag_t        out_tag,
  output logic [NW-1:0]    out_num,
  output logic [QW-1:0]    out_den
);

  localparam int EW  = CB + 1;
  localparam int SQW = 2 * EW;
  localparam int ESW = SQW + 2;
  localparam int SW  = SQW + 5;
  localparam int CRW = 2 * EW + 1;
  localparam int TW  = EW + CRW;
  localparam int DW  = TW + 2;
  localparam int EU [6] = '{0, 0, 0, 1, 1, 2};
  localparam int EV [6] = '{1, 2, 3, 2, 3, 3};

  function automatic logic signed [CB-1:0] crd(input logic signed [IN_W-1:0] f);
    logic signed [31:0] w;
    w = 32'(f);
    return w[CB-1:0];
  endfunction

  logic signed [CB-1:0] p [4][3];

  // corner decode
  always_comb begin
    p[0][0] = crd(in_beat.a_x); p[0][1] = crd(in_beat.a_y); p[0][2] = crd(in_beat.a_z);
    p[1][0] = crd(in_beat.b_x); p[1][1] = crd(in_beat.b_y); p[1][2] = crd(in_beat.b_z);
    p[2][0] = crd(in_beat.c_x); p[2][1] = crd(in_beat.c_y); p[2][2] = crd(in_beat.c_z);
    p[3][0] = crd(in_beat.d_x); p[3][1] = crd(in_beat.d_y); p[3][2] = crd(in_beat.d_z);
  end

  logic [12:1] v;

  // valid shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[11:1], in_valid};
    end
  end

  // stage 1: edge vectors
  logic signed [EW-1:0] ed [6][3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [EW-1:0] e3 [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      for (int j = 0; j < 3; j++) begin
        ed[k][j] <= EW'(p[EU[k]][j]) - EW'(p[EV[k]][j]);
      end
    end
    for (int j = 0; j < 3; j++) begin
      e1[j] <= EW'(p[1][j]) - EW'(p[0][j]);
      e2[j] <= EW'(p[2][j]) - EW'(p[0][j]);
      e3[j] <= EW'(p[3][j]) - EW'(p[0][j]);
    end
  end

  // stage 2: squares and cross product terms
  logic signed [SQW-1:0] sq [6][3];
  logic signed [SQW-1:0] mp [6];
  logic signed [EW-1:0]  e3_2 [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      for (int j = 0; j < 3; j++) begin
        sq[k][j] <= ed[k][j] * ed[k][j];
      end
    end
    mp[0] <= e1[1] * e2[2];
    mp[1] <= e1[2] * e2[1];
    mp[2] <= e1[2] * e2[0];
    mp[3] <= e1[0] * e2[2];
    mp[4] <= e1[0] * e2[1];
    mp[5] <= e1[1] * e2[0];
    e3_2  <= e3;
  end

  // stage 3: per-edge sums and cross product
  logic [ESW-1:0]        es [6];
  logic signed [CRW-1:0] cr [3];
  logic signed [EW-1:0]  e3_3 [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      es[k] <= ESW'($unsigned(sq[k][0])) + ESW'($unsigned(sq[k][1]))
             + ESW'($unsigned(sq[k][2]));
    end
    cr[0] <= CRW'(mp[0]) - CRW'(mp[1]);
    cr[1] <= CRW'(mp[2]) - CRW'(mp[3]);
    cr[2] <= CRW'(mp[4]) - CRW'(mp[5]);
    e3_3  <= e3_2;
  end

  // stage 4: sum of squared edge lengths and volume terms
  logic [SW-1:0]        s4;
  logic signed [TW-1:0] t [3];

  always_ff @(posedge clk) begin
    s4 <= SW'(es[0]) + SW'(es[1]) + SW'(es[2]) + SW'(es[3]) + SW'(es[4]) + SW'(es[5]);
    for (int j = 0; j < 3; j++) begin
      t[j] <= e3_3[j] * cr[j];
    end
  end

  // stage 5: six times the signed volume
  logic [SW-1:0]        s5;
  logic signed [DW-1:0] dv;

  always_ff @(posedge clk) begin
    s5 <= s4;
    dv <= DW'(t[0]) + DW'(t[1]) + DW'(t[2]);
  end

  // stage 6: magnitude and flags
  logic [DW-1:0]   mag;
  logic [SW-1:0]   s6;
  tevq_tag_t       tag6;

  always_ff @(posedge clk) begin
    mag       <= dv[DW-1] ? DW'(-dv) : DW'(dv);
    tag6.neg  <= dv[DW-1];
    tag6.zero <= (dv == '0);
    s6        <= s5;
  end

  // stages 7 to 9: D squared, S squared, S times the denominator constant
  logic [2*DW-1:0]     d2;
  logic [2*SW-1:0]     s2;
  logic [F10_W+SW-1:0] fs;

  tevq_mul #(.AW(DW), .BW(DW), .PW(2*DW)) u_d2 (
    .clk (clk),
    .a   (mag),
    .b   (mag),
    .p   (d2)
  );

  tevq_mul #(.AW(SW), .BW(SW), .PW(2*SW)) u_s2 (
    .clk (clk),
    .a   (s6),
    .b   (s6),
    .p   (s2)
  );

  tevq_mul #(.AW(F10_W), .BW(SW), .PW(F10_W+SW)) u_fs (
    .clk (clk),
    .a   (F10),
    .b   (s6),
    .p   (fs)
  );

  // stages 10 to 12: apply the reduced constants
  tevq_mul #(.AW(CN_W), .BW(2*DW), .PW(NW)) u_num (
    .clk (clk),
    .a   (CN),
    .b   (d2),
    .p   (out_num)
  );

  tevq_mul #(.AW(F10_W+SW), .BW(2*SW), .PW(QW)) u_den (
    .clk (clk),
    .a   (fs),
    .b   (s2),
    .p   (out_den)
  );

  // flags follow the multipliers
  tevq_tag_t tag_d [6];

  always_ff @(posedge clk) begin
    tag_d[0] <= tag6;
    for (int k = 1; k < 6; k++) begin
      tag_d[k] <= tag_d[k-1];
    end
  end

  assign out_tag   = tag_d[5];
  assign out_valid = v[12];

endmodule

### rtl/tevq_div.sv
// tevq_div: pipelined restoring divider, one quotient bit per stage
// depends on tevq_pkg; divides num * 2^SH by den
module tevq_div import tevq_pkg::*; #(
  parameter int NW = 140,
  parameter int QW = 141,
  parameter int SH = 60,
  parameter int QB = 63
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  tevq_tag_t     in_tag,
  input  logic [NW-1:0] in_num,
  input  logic [QW-1:0] in_den,
  output logic          out_valid,
  output tevq_tag_t     out_tag,
  output logic [QB-1:0] out_quot
);

  localparam int DVW = NW + SH;

  logic [DVW-1:0] dvd;
  assign dvd = {in_num, SH'(0)};

  logic            v   [QB+1];
  tevq_tag_t       tg  [QB+1];
  logic [QW-1:0]   rem [QB+1];
  logic [QW-1:0]   dn  [QB+1];
  logic [QB-1:0]   lo  [QB+1];
  logic [QB-1:0]   qt  [QB+1];

  // entry: high part of the dividend is the first partial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
    tg[0]  <= in_tag;
    rem[0] <= QW'(dvd >> QB);
    dn[0]  <= in_den;
    lo[0]  <= dvd[QB-1:0];
    qt[0]  <= '0;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [QW:0] r2;
    logic        ge;

    always_comb begin
      r2 = {rem[k], lo[k][QB-1]};
      ge = (r2 >= {1'b0, dn[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      tg[k+1]  <= tg[k];
      rem[k+1] <= ge ? QW'(r2 - {1'b0, dn[k]}) : QW'(r2);
      dn[k+1]  <= dn[k];
      lo[k+1]  <= lo[k] << 1;
      qt[k+1]  <= {qt[k][QB-2:0], ge};
    end
  end

  assign out_valid = v[QB];
  assign out_tag   = tg[QB];
  assign out_quot  = qt[QB];

endmodule

### rtl/tevq_sqrt.sv
// tevq_sqrt: pipelined integer square root, one root bit per stage
// depends on tevq_pkg
module tevq_sqrt import tevq_pkg::*; #(
  parameter int QB = 63,
  parameter int RB = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  tevq_tag_t     in_tag,
  input  logic [QB-1:0] in_val,
  output logic          out_valid,
  output tevq_tag_t     out_tag,
  output logic [RB-1:0] out_root
);

  localparam int XW = 2 * RB;

  logic            v   [RB+1];
  tevq_tag_t       tg  [RB+1];
  logic [XW-1:0]   x   [RB+1];
  logic [RB+1:0]   rem [RB+1];
  logic [RB-1:0]   rt  [RB+1];

  // entry
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
    tg[0]  <= in_tag;
    x[0]   <= XW'(in_val);
    rem[0] <= '0;
    rt[0]  <= '0;
  end

  // two radicand bits in, one root bit out per stage
  for (genvar k = 0; k < RB; k++) begin : g_step
    logic [RB+1:0] r2;
    logic [RB+1:0] trial;
    logic          ge;

    always_comb begin
      r2    = {rem[k][RB-1:0], x[k][XW-1:XW-2]};
      trial = {rt[k], 2'b01};
      ge    = (r2 >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      tg[k+1]  <= tg[k];
      x[k+1]   <= x[k] << 2;
      rem[k+1] <= ge ? (r2 - trial) : r2;
      rt[k+1]  <= {rt[k][RB-2:0], ge};
    end
  end

  assign out_valid = v[RB];
  assign out_tag   = tg[RB];
  assign out_root  = rt[RB];

endmodule
